[src/trm_pkg.sv]
// trm_pkg: shared constants, state and step codes, and the command and status
// structs that join the trapezoid rms controller and datapath
// depends on nothing
`default_nettype none

package trm_pkg;

   localparam int SIGNAL_BITS_DEF = 16;
   localparam int INDEP_BITS_DEF  = 24;

   localparam int SUM_BITS    = 64;
   localparam int WIN_BITS    = 40;
   localparam int ROOT_BITS   = SUM_BITS / 2;
   localparam int PCOUNT_BITS = 2;
   localparam int ITER_BITS   = $clog2(SUM_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_CUR,
      ST_SQ_PREV,
      ST_SQ_SUM,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_PROD_SUM,
      ST_COMMIT,
      ST_CHECK,
      ST_DIV,
      ST_ROOT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_LOAD,
      STEP_SQ_CUR,
      STEP_SQ_PREV,
      STEP_SQ_SUM,
      STEP_MUL_LO,
      STEP_MUL_HI,
      STEP_PROD_SUM,
      STEP_COMMIT,
      STEP_CHECK,
      STEP_DIV,
      STEP_ROOT,
      STEP_OUT
   } step_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic window_end;
      logic result_ok;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[src/trm_req_if.sv]
// trm_req_if: sample channel, valid/ready handshake with the sample payload
// depends on trm_pkg for default widths
`default_nettype none

interface trm_req_if #(
   parameter int INDEP_BITS  = trm_pkg::INDEP_BITS_DEF,
   parameter int SIGNAL_BITS = trm_pkg::SIGNAL_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [INDEP_BITS-1:0]  indep_val;
   logic signed [SIGNAL_BITS-1:0] signal_val;
   logic                          window_start;
   logic                          window_end;

   modport source (output valid, indep_val, signal_val, window_start, window_end,
                   input ready);
   modport sink (input valid, indep_val, signal_val, window_start, window_end,
                 output ready);
endinterface

`default_nettype wire

[src/trm_rsp_if.sv]
// trm_rsp_if: result channel, valid/ready handshake with the rms payload
// depends on trm_pkg for default widths
`default_nettype none

interface trm_rsp_if #(
   parameter int SIGNAL_BITS = trm_pkg::SIGNAL_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SIGNAL_BITS-1:0] rms_val;
   logic                   rms_valid;

   modport source (output valid, rms_val, rms_valid, input ready);
   modport sink (input valid, rms_val, rms_valid, output ready);
endinterface

`default_nettype wire

[src/trm_ctrl.sv]
// trm_ctrl: sequencer for the trapezoid rms meter, steps the shared multiplier,
// divider and root iterations; depends on trm_pkg
`default_nettype none

module trm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  trm_pkg::status_type status,
   output trm_pkg::cmd_type    cmd
);

   localparam int ITER_BITS = trm_pkg::ITER_BITS;

   trm_pkg::state_type   state_ff, state_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trm_pkg::ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin : next_state
      state_in = state_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         trm_pkg::ST_IDLE: begin
            if (req_valid) state_in = trm_pkg::ST_SQ_CUR;
         end
         trm_pkg::ST_SQ_CUR: begin
            // opening sample of a window only records
            state_in = status.first ? trm_pkg::ST_COMMIT : trm_pkg::ST_SQ_PREV;
         end
         trm_pkg::ST_SQ_PREV:  state_in = trm_pkg::ST_SQ_SUM;
         trm_pkg::ST_SQ_SUM:   state_in = trm_pkg::ST_MUL_LO;
         trm_pkg::ST_MUL_LO:   state_in = trm_pkg::ST_MUL_HI;
         trm_pkg::ST_MUL_HI:   state_in = trm_pkg::ST_PROD_SUM;
         trm_pkg::ST_PROD_SUM: state_in = trm_pkg::ST_COMMIT;
         trm_pkg::ST_COMMIT: begin
            state_in = status.window_end ? trm_pkg::ST_CHECK : trm_pkg::ST_IDLE;
         end
         trm_pkg::ST_CHECK: begin
            if (status.result_ok) begin
               state_in = trm_pkg::ST_DIV;
               iter_in  = ITER_BITS'(trm_pkg::SUM_BITS - 1);
            end else begin
               state_in = trm_pkg::ST_OUT;
            end
         end
         trm_pkg::ST_DIV: begin
            if (iter_ff == '0) begin
               state_in = trm_pkg::ST_ROOT;
               iter_in  = ITER_BITS'(trm_pkg::ROOT_BITS - 1);
            end else begin
               iter_in = iter_ff - ITER_BITS'(1);
            end
         end
         trm_pkg::ST_ROOT: begin
            if (iter_ff == '0) begin
               state_in = trm_pkg::ST_OUT;
            end else begin
               iter_in = iter_ff - ITER_BITS'(1);
            end
         end
         trm_pkg::ST_OUT: begin
            if (status.out_free) state_in = trm_pkg::ST_IDLE;
         end
         default: state_in = trm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin : outputs
      req_ready = (state_ff == trm_pkg::ST_IDLE);
      cmd.step  = trm_pkg::STEP_NONE;
      unique case (state_ff)
         trm_pkg::ST_IDLE: begin
            if (req_valid) cmd.step = trm_pkg::STEP_LOAD;
         end
         trm_pkg::ST_SQ_CUR:   cmd.step = trm_pkg::STEP_SQ_CUR;
         trm_pkg::ST_SQ_PREV:  cmd.step = trm_pkg::STEP_SQ_PREV;
         trm_pkg::ST_SQ_SUM:   cmd.step = trm_pkg::STEP_SQ_SUM;
         trm_pkg::ST_MUL_LO:   cmd.step = trm_pkg::STEP_MUL_LO;
         trm_pkg::ST_MUL_HI:   cmd.step = trm_pkg::STEP_MUL_HI;
         trm_pkg::ST_PROD_SUM: cmd.step = trm_pkg::STEP_PROD_SUM;
         trm_pkg::ST_COMMIT:   cmd.step = trm_pkg::STEP_COMMIT;
         trm_pkg::ST_CHECK:    cmd.step = trm_pkg::STEP_CHECK;
         trm_pkg::ST_DIV:      cmd.step = trm_pkg::STEP_DIV;
         trm_pkg::ST_ROOT:     cmd.step = trm_pkg::STEP_ROOT;
         trm_pkg::ST_OUT: begin
            if (status.out_free) cmd.step = trm_pkg::STEP_OUT;
         end
         default: cmd.step = trm_pkg::STEP_NONE;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == trm_pkg::ST_SQ_CUR)
      else $error("accepted sample did not start the square step");

   a_div_to_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trm_pkg::ST_DIV && iter_ff == '0)
      |=> (state_ff == trm_pkg::ST_ROOT && iter_ff == ITER_BITS'(trm_pkg::ROOT_BITS - 1)))
      else $error("divider did not hand over to the root iterations");

   a_mid_window_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trm_pkg::ST_COMMIT && !status.window_end) |=> req_ready)
      else $error("input not free after a mid-window sample");
`endif

endmodule

`default_nettype wire

[src/trm_datapath.sv]
// trm_datapath: window accumulators, shared multiplier, restoring divider,
// digit-by-digit square root and result register; depends on trm_pkg
`default_nettype none

module trm_datapath #(
   parameter int SIGNAL_BITS = trm_pkg::SIGNAL_BITS_DEF,
   parameter int INDEP_BITS  = trm_pkg::INDEP_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  trm_pkg::cmd_type              cmd,
   output trm_pkg::status_type           status,
   input  logic signed [INDEP_BITS-1:0]  req_indep_val,
   input  logic signed [SIGNAL_BITS-1:0] req_signal_val,
   input  logic                          req_window_start,
   input  logic                          req_window_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SIGNAL_BITS-1:0]        rsp_rms_val,
   output logic                          rsp_rms_valid
);

   localparam int SUM_BITS    = trm_pkg::SUM_BITS;
   localparam int WIN_BITS    = trm_pkg::WIN_BITS;
   localparam int ROOT_BITS   = trm_pkg::ROOT_BITS;
   localparam int PCOUNT_BITS = trm_pkg::PCOUNT_BITS;
   localparam int DX_BITS     = INDEP_BITS + 1;
   localparam int MA_BITS     = (DX_BITS > SIGNAL_BITS) ? DX_BITS : SIGNAL_BITS;
   localparam int MW_BITS     = MA_BITS + SIGNAL_BITS;
   localparam int SQ_BITS     = 2 * SIGNAL_BITS;
   localparam int PW_BITS     = DX_BITS + SQ_BITS;
   localparam int PRW_BITS    = (PW_BITS > SUM_BITS) ? PW_BITS : SUM_BITS;
   localparam int WW_BITS     = ((WIN_BITS > DX_BITS) ? WIN_BITS : DX_BITS) + 1;
   localparam int DEN_BITS    = WIN_BITS + 1;
   localparam int RREM_BITS   = ROOT_BITS + 2;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic signed [WIN_BITS-1:0] WIN_MAX = {1'b0, {(WIN_BITS-1){1'b1}}};
   localparam logic signed [WIN_BITS-1:0] WIN_MIN = {1'b1, {(WIN_BITS-1){1'b0}}};
   localparam logic [ROOT_BITS-1:0] FULL_SCALE = ROOT_BITS'(1) << (SIGNAL_BITS - 1);

   // window state, cleared by reset
   logic signed [INDEP_BITS-1:0]  prev_indep_ff, prev_indep_in;
   logic signed [SIGNAL_BITS-1:0] prev_signal_ff, prev_signal_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [WIN_BITS-1:0]    win_ff, win_in;
   logic [PCOUNT_BITS-1:0]        pcount_ff, pcount_in;
   logic                          started_ff, started_in;
   logic                          first_ff, first_in;
   logic                          wend_ff, wend_in;
   logic                          result_ok_ff, result_ok_in;
   logic                          pending_ff, pending_in;

   // working registers
   logic signed [INDEP_BITS-1:0]  cur_indep_ff, cur_indep_in;
   logic signed [SIGNAL_BITS-1:0] cur_signal_ff, cur_signal_in;
   logic signed [DX_BITS-1:0]     dx_ff, dx_in;
   logic [MW_BITS-1:0]            mul_ff, mul_in;
   logic [SQ_BITS-1:0]            sq_ff, sq_in;
   logic [PW_BITS-1:0]            prod_ff, prod_in;
   logic [SUM_BITS-1:0]           dvd_ff, dvd_in;
   logic [DEN_BITS-1:0]           rem_ff, rem_in;
   logic [DEN_BITS-1:0]           den_ff, den_in;
   logic [ROOT_BITS-1:0]          root_ff, root_in;
   logic [RREM_BITS-1:0]          rrem_ff, rrem_in;
   logic [SIGNAL_BITS-1:0]        rms_ff, rms_in;
   logic                          rms_ok_ff, rms_ok_in;

   // magnitudes
   logic [SIGNAL_BITS-1:0] cur_mag, prev_mag;
   logic [DX_BITS-1:0]     dx_mag;
   logic [SUM_BITS-1:0]    sum_mag;
   logic [WIN_BITS-1:0]    win_mag;

   assign cur_mag  = cur_signal_ff[SIGNAL_BITS-1] ? SIGNAL_BITS'(-cur_signal_ff)
                                                  : SIGNAL_BITS'(cur_signal_ff);
   assign prev_mag = prev_signal_ff[SIGNAL_BITS-1] ? SIGNAL_BITS'(-prev_signal_ff)
                                                   : SIGNAL_BITS'(prev_signal_ff);
   assign dx_mag   = dx_ff[DX_BITS-1] ? DX_BITS'(-dx_ff) : DX_BITS'(dx_ff);
   assign sum_mag  = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign win_mag  = win_ff[WIN_BITS-1] ? WIN_BITS'(-win_ff) : WIN_BITS'(win_ff);

   // result validity from the committed window state
   logic result_ok_now;

   assign result_ok_now = started_ff && (pcount_ff >= PCOUNT_BITS'(2)) && (win_ff != '0)
                          && !((sum_ff != '0)
                               && (sum_ff[SUM_BITS-1] != win_ff[WIN_BITS-1]));

   // shared multiplier: squares, then |dx| times the two halves of the square sum
   logic [MA_BITS-1:0]     mul_a;
   logic [SIGNAL_BITS-1:0] mul_b;
   logic [MW_BITS-1:0]     mul_prod;

   always_comb begin
      unique case (cmd.step)
         trm_pkg::STEP_SQ_CUR: begin
            mul_a = MA_BITS'(cur_mag);
            mul_b = cur_mag;
         end
         trm_pkg::STEP_SQ_PREV: begin
            mul_a = MA_BITS'(prev_mag);
            mul_b = prev_mag;
         end
         trm_pkg::STEP_MUL_LO: begin
            mul_a = MA_BITS'(dx_mag);
            mul_b = sq_ff[SIGNAL_BITS-1:0];
         end
         trm_pkg::STEP_MUL_HI: begin
            mul_a = MA_BITS'(dx_mag);
            mul_b = sq_ff[SQ_BITS-1:SIGNAL_BITS];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = MW_BITS'(mul_a) * MW_BITS'(mul_b);

   // trapezoid term, saturated magnitude with the sign of dx
   logic [PRW_BITS-1:0]       prod_wide;
   logic [SUM_BITS-2:0]       term_mag;
   logic signed [SUM_BITS:0]  term_pos, term, sum_wide;
   logic signed [SUM_BITS-1:0] sum_sat;

   assign prod_wide = PRW_BITS'(prod_ff);
   assign term_mag  = (|prod_wide[PRW_BITS-1:SUM_BITS-1]) ? '1 : prod_wide[SUM_BITS-2:0];
   assign term_pos  = {2'b00, term_mag};
   assign term      = dx_ff[DX_BITS-1] ? -term_pos : term_pos;
   assign sum_wide  = (SUM_BITS+1)'(sum_ff) + term;

   always_comb begin
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_BITS-1:0];
      end
   end

   // window length, saturating
   logic signed [WW_BITS-1:0]  win_wide;
   logic signed [WIN_BITS-1:0] win_low, win_sat;

   assign win_wide = WW_BITS'(win_ff) + WW_BITS'(dx_ff);
   assign win_low  = win_wide[WIN_BITS-1:0];

   always_comb begin
      if (WW_BITS'(win_low) == win_wide) begin
         win_sat = win_low;
      end else begin
         win_sat = win_wide[WW_BITS-1] ? WIN_MIN : WIN_MAX;
      end
   end

   // restoring divider, one quotient bit a step
   logic [DEN_BITS:0] rem_sh, rem_diff;
   logic              div_ge;

   assign rem_sh   = {rem_ff, dvd_ff[SUM_BITS-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign div_ge   = rem_sh >= {1'b0, den_ff};

   // square root, two radicand bits a step
   logic [RREM_BITS+1:0] rrem_sh, root_trial, rrem_diff;
   logic                 root_ge;

   assign rrem_sh    = {rrem_ff, dvd_ff[SUM_BITS-1:SUM_BITS-2]};
   assign root_trial = {2'b00, root_ff, 2'b01};
   assign rrem_diff  = rrem_sh - root_trial;
   assign root_ge    = rrem_sh >= root_trial;

   always_comb begin
      prev_indep_in  = prev_indep_ff;
      prev_signal_in = prev_signal_ff;
      sum_in         = sum_ff;
      win_in         = win_ff;
      pcount_in      = pcount_ff;
      started_in     = started_ff;
      first_in       = first_ff;
      wend_in        = wend_ff;
      result_ok_in   = result_ok_ff;
      cur_indep_in   = cur_indep_ff;
      cur_signal_in  = cur_signal_ff;
      dx_in          = dx_ff;
      mul_in         = mul_ff;
      sq_in          = sq_ff;
      prod_in        = prod_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      root_in        = root_ff;
      rrem_in        = rrem_ff;
      rms_in         = rms_ff;
      rms_ok_in      = rms_ok_ff;

      unique case (cmd.step)
         trm_pkg::STEP_LOAD: begin
            cur_indep_in  = req_indep_val;
            cur_signal_in = req_signal_val;
            dx_in         = DX_BITS'(req_indep_val) - DX_BITS'(prev_indep_ff);
            first_in      = req_window_start || !started_ff;
            wend_in       = req_window_end;
            if (req_window_start) begin
               sum_in     = '0;
               win_in     = '0;
               pcount_in  = '0;
               started_in = 1'b0;
            end
         end
         trm_pkg::STEP_SQ_CUR: begin
            mul_in = mul_prod;
         end
         trm_pkg::STEP_SQ_PREV: begin
            mul_in = mul_prod;
            sq_in  = mul_ff[SQ_BITS-1:0];
         end
         trm_pkg::STEP_SQ_SUM: begin
            sq_in = sq_ff + mul_ff[SQ_BITS-1:0];
         end
         trm_pkg::STEP_MUL_LO: begin
            mul_in = mul_prod;
         end
         trm_pkg::STEP_MUL_HI: begin
            mul_in  = mul_prod;
            prod_in = PW_BITS'(mul_ff);
         end
         trm_pkg::STEP_PROD_SUM: begin
            prod_in = prod_ff + (PW_BITS'(mul_ff) << SIGNAL_BITS);
         end
         trm_pkg::STEP_COMMIT: begin
            if (first_ff) begin
               started_in = 1'b1;
               pcount_in  = PCOUNT_BITS'(1);
            end else begin
               sum_in = sum_sat;
               win_in = win_sat;
               if (pcount_ff != '1) pcount_in = pcount_ff + PCOUNT_BITS'(1);
            end
            prev_indep_in  = cur_indep_ff;
            prev_signal_in = cur_signal_ff;
         end
         trm_pkg::STEP_CHECK: begin
            result_ok_in = result_ok_now;
            dvd_in  = sum_mag;
            rem_in  = '0;
            den_in  = {win_mag, 1'b0};
            root_in = '0;
            rrem_in = '0;
         end
         trm_pkg::STEP_DIV: begin
            rem_in = div_ge ? rem_diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
            dvd_in = {dvd_ff[SUM_BITS-2:0], div_ge};
         end
         trm_pkg::STEP_ROOT: begin
            rrem_in = root_ge ? rrem_diff[RREM_BITS-1:0] : rrem_sh[RREM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], root_ge};
            dvd_in  = {dvd_ff[SUM_BITS-3:0], 2'b00};
         end
         trm_pkg::STEP_OUT: begin
            if (!result_ok_ff) begin
               rms_in = '0;
            end else if (root_ff > FULL_SCALE) begin
               rms_in = SIGNAL_BITS'(FULL_SCALE);
            end else begin
               rms_in = SIGNAL_BITS'(root_ff);
            end
            rms_ok_in = result_ok_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (cmd.step == trm_pkg::STEP_OUT) begin
         pending_in = 1'b1;
      end else if (rsp_ready) begin
         pending_in = 1'b0;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_indep_ff  <= '0;
         prev_signal_ff <= '0;
         sum_ff         <= '0;
         win_ff         <= '0;
         pcount_ff      <= '0;
         started_ff     <= 1'b0;
         first_ff       <= 1'b0;
         wend_ff        <= 1'b0;
         result_ok_ff   <= 1'b0;
         pending_ff     <= 1'b0;
      end else begin
         prev_indep_ff  <= prev_indep_in;
         prev_signal_ff <= prev_signal_in;
         sum_ff         <= sum_in;
         win_ff         <= win_in;
         pcount_ff      <= pcount_in;
         started_ff     <= started_in;
         first_ff       <= first_in;
         wend_ff        <= wend_in;
         result_ok_ff   <= result_ok_in;
         pending_ff     <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_indep_ff  <= cur_indep_in;
      cur_signal_ff <= cur_signal_in;
      dx_ff         <= dx_in;
      mul_ff        <= mul_in;
      sq_ff         <= sq_in;
      prod_ff       <= prod_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      root_ff       <= root_in;
      rrem_ff       <= rrem_in;
      rms_ff        <= rms_in;
      rms_ok_ff     <= rms_ok_in;
   end

   assign status.first      = first_ff;
   assign status.window_end = wend_ff;
   assign status.result_ok  = result_ok_now;
   assign status.out_free   = !pending_ff || rsp_ready;

   assign rsp_valid     = pending_ff;
   assign rsp_rms_val   = rms_ff;
   assign rsp_rms_valid = rms_ok_ff;

`ifndef SYNTHESIS
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step == trm_pkg::STEP_DIV |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_root_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step == trm_pkg::STEP_ROOT |-> rrem_ff <= {1'b0, root_ff, 1'b0})
      else $error("root remainder above twice the partial root");

   a_commit_opens: assert property (@(posedge clock) disable iff (reset)
      cmd.step == trm_pkg::STEP_COMMIT |=> (started_ff && pcount_ff != '0))
      else $error("window not open after a committed sample");
`endif

endmodule

`default_nettype wire

[src/trapezoid_rms_meter.sv]
// trapezoid_rms_meter: true rms of a sampled signal over a window, by
// trapezoidal integration; depends on trm_pkg, trm_req_if, trm_rsp_if,
// trm_ctrl and trm_datapath
//
//   channel   dir  payload                                          transfer when
//   req_chan  in   indep_val, signal_val, window_start, window_end  valid && ready
//   rsp_chan  out  rms_val, rms_valid                               valid && ready
//
// sequence: the opening sample of a window only records; for every later sample
//   the shared multiplier forms two squares and then |dx| times the square sum
//   in two halves; a sample marked window_end then runs the check, the 64-step
//   restoring divider, the 32-step square root and the output step when the
//   result is valid, and only the check and the output step when it is not
// reset: synchronous; sums, window length and point count clear, and the
//   first sample after reset only records, as for an opened window
// stalls: a result waits in the output register while the next sample is
//   taken; a second result waits in the sequencer until the first is taken
`default_nettype none

module trapezoid_rms_meter #(
   parameter int SIGNAL_BITS = trm_pkg::SIGNAL_BITS_DEF,
   parameter int INDEP_BITS  = trm_pkg::INDEP_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   trm_req_if.sink   req_chan,
   trm_rsp_if.source rsp_chan
);

   // command and status between sequencer and datapath
   trm_pkg::cmd_type    cmd;
   trm_pkg::status_type status;

   logic                   req_ready;
   logic                   rsp_valid;
   logic [SIGNAL_BITS-1:0] rsp_rms_val;
   logic                   rsp_rms_valid;

   // sequencer: owns the input handshake and the iteration counter
   trm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: accumulators, multiplier, divider, root and result register
   trm_datapath #(
      .SIGNAL_BITS (SIGNAL_BITS),
      .INDEP_BITS  (INDEP_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_indep_val    (req_chan.indep_val),
      .req_signal_val   (req_chan.signal_val),
      .req_window_start (req_chan.window_start),
      .req_window_end   (req_chan.window_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_rms_val      (rsp_rms_val),
      .rsp_rms_valid    (rsp_rms_valid)
   );

   // channel hookup
   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.rms_val   = rsp_rms_val;
   assign rsp_chan.rms_valid = rsp_rms_valid;

endmodule

`default_nettype wire
